// File: sv/prld_pkg.sv
// Shared types and constants for the PCX run-length line decoder.
// Used by prld_ctrl, prld_datapath and pcx_rle_line_decoder; no dependencies.
`default_nettype none

package prld_pkg;

    // Byte classification: top two bits set marks a run key
    localparam logic [7:0] KEY_MASK   = 8'hc0;
    localparam logic [7:0] COUNT_MASK = 8'h3f;
    localparam int         COUNT_W    = 6;

    // Configuration port
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int LINE_WIDTH_RST = 320;
    localparam int BYTES_PER_LINE_RST = 320;
    localparam int LINE_COUNT_RST = 200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH     = 2'd0,
        CFG_BYTES_PER_LINE = 2'd1,
        CFG_LINE_COUNT     = 2'd2
    } t_cfg_index;

    // Controller states, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // take the accepted input byte
        logic step;   // decode one repetition of the current run
        logic flush;  // send the held pixel as the last of its item
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic tot_ok;       // pixel total is up to date with the registers
        logic finished;     // image complete, inputs are ignored
        logic await_value;  // a key was seen, next byte is the run value
        logic byte_is_key;  // the input byte is a key
        logic count_zero;   // stored run count is zero
        logic reps_last;    // one repetition left in the run
        logic step_fin;     // a step now would emit the final image pixel
        logic hold_valid;   // a decoded pixel waits in the hold stage
        logic out_free;     // output register can take a pixel this cycle
    } t_status;

endpackage

`default_nettype wire

// File: sv/prld_ctrl.sv
// Controller of the PCX run-length line decoder: input handshake and run sequencing.
// Depends on prld_pkg; drives commands to prld_datapath.
`default_nettype none

module prld_ctrl
    import prld_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   in_accept;
    logic   starts_run;

    // Accept only in idle, with the total settled and the hold stage able to drain
    always_comb begin
        o_in_stall = 1'b1;
        if (r_state == S_IDLE) begin
            o_in_stall = !(i_status.tot_ok &&
                           (!i_status.hold_valid || i_status.out_free));
        end
    end

    assign in_accept = i_in_valid && !o_in_stall;

    // An item starts a run if the image is not finished and it is a literal or a run value with non-zero count
    assign starts_run = !i_status.finished &&
                        ((i_status.await_value && !i_status.count_zero) ||
                         (!i_status.await_value && !i_status.byte_is_key));

    // Commands and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                o_cmd.flush = i_status.hold_valid && i_status.out_free;
                o_cmd.load  = in_accept;
                if (in_accept && starts_run) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.step = i_status.out_free || !i_status.hold_valid;
                if (o_cmd.step && (i_status.reps_last || i_status.step_fin)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: sv/prld_datapath.sv
// Datapath of the PCX run-length line decoder: registers, run state, column and
// pixel counters, hold stage and output register. Depends on prld_pkg.
`default_nettype none

module prld_datapath
    import prld_pkg::*;
#(
    parameter int DIM_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_out_stall,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status,
    output logic                      o_out_valid,
    output logic [7:0]                o_pixel,
    output logic                      o_last_of_run,
    output logic                      o_image_done
);

    localparam int PW = 2 * DIM_BITS;

    // Configuration and derived total
    logic [DIM_BITS-1:0] r_line_width;
    logic [DIM_BITS-1:0] r_bytes_per_line;
    logic [DIM_BITS-1:0] r_line_count;
    logic [PW-1:0]       r_total;
    logic                r_tot_ok;

    // Decode state
    logic               r_await;
    logic [COUNT_W-1:0] r_count;
    logic [7:0]         r_value;
    logic [COUNT_W-1:0] r_reps_left;
    logic [DIM_BITS-1:0] r_col;
    logic [PW-1:0]      r_pix_cnt;
    logic               r_finished;

    // Hold stage and output register
    logic       r_hold_valid;
    logic [7:0] r_hold_pixel;
    logic       r_hold_done;
    logic       r_out_valid;
    logic [7:0] r_out_pixel;
    logic       r_out_last;
    logic       r_out_done;

    logic                col_vis;
    logic [DIM_BITS-1:0] n_col_inc;
    logic [DIM_BITS-1:0] n_col;
    logic [PW-1:0]       n_pix_cnt;
    logic [PW-1:0]       n_total;
    logic                step_fin;
    logic                out_free;

    // Column advance and pixel count for one repetition
    always_comb begin
        col_vis   = r_col < r_line_width;
        n_col_inc = r_col + DIM_BITS'(1);
        n_col     = (n_col_inc >= r_bytes_per_line) ? '0 : n_col_inc;
        n_pix_cnt = r_pix_cnt + PW'(1);
        step_fin  = col_vis && (n_pix_cnt == r_total);
        n_total   = PW'(r_line_width) * PW'(r_line_count);
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // Status to the controller
    always_comb begin
        o_status             = '0;
        o_status.tot_ok      = r_tot_ok;
        o_status.finished    = r_finished;
        o_status.await_value = r_await;
        o_status.byte_is_key = (i_data_byte & KEY_MASK) == KEY_MASK;
        o_status.count_zero  = r_count == '0;
        o_status.reps_last   = r_reps_left == COUNT_W'(1);
        o_status.step_fin    = step_fin;
        o_status.hold_valid  = r_hold_valid;
        o_status.out_free    = out_free;
    end

    // Configuration registers; the total is re-registered in the cycle after a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width     <= DIM_BITS'(LINE_WIDTH_RST);
            r_bytes_per_line <= DIM_BITS'(BYTES_PER_LINE_RST);
            r_line_count     <= DIM_BITS'(LINE_COUNT_RST);
            r_tot_ok         <= 1'b0;
        end else begin
            r_tot_ok <= !i_cfg_wr_en;
            if (i_cfg_wr_en) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_LINE_WIDTH:     r_line_width     <= i_cfg_data[DIM_BITS-1:0];
                    CFG_BYTES_PER_LINE: r_bytes_per_line <= i_cfg_data[DIM_BITS-1:0];
                    CFG_LINE_COUNT:     r_line_count     <= i_cfg_data[DIM_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= n_total;
    end

    // Run state, counters and hold valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await      <= 1'b0;
            r_count      <= '0;
            r_col        <= '0;
            r_pix_cnt    <= '0;
            r_finished   <= 1'b0;
            r_hold_valid <= 1'b0;
        end else begin
            if (i_cmd.load && !r_finished) begin
                if (r_await) begin
                    r_await <= 1'b0;
                    r_count <= '0;
                end else if ((i_data_byte & KEY_MASK) == KEY_MASK) begin
                    r_await <= 1'b1;
                    r_count <= COUNT_W'(i_data_byte & COUNT_MASK);
                end
            end
            if (i_cmd.flush) begin
                r_hold_valid <= 1'b0;
            end
            if (i_cmd.step) begin
                r_col <= n_col;
                if (col_vis) begin
                    r_pix_cnt    <= n_pix_cnt;
                    r_hold_valid <= 1'b1;
                    if (step_fin) begin
                        r_finished <= 1'b1;
                    end
                end
            end
        end
    end

    // Run value, repetition count and hold payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_data_byte;
            if (r_await) begin
                r_reps_left <= r_count;
            end else begin
                r_reps_left <= COUNT_W'(1);
            end
        end else if (i_cmd.step) begin
            r_reps_left <= r_reps_left - COUNT_W'(1);
        end
        if (i_cmd.step && col_vis) begin
            r_hold_pixel <= r_value;
            r_hold_done  <= step_fin;
        end
    end

    // Output register: a held pixel moves on when a newer one displaces it or on flush
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.flush || (i_cmd.step && col_vis && r_hold_valid)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.flush || (i_cmd.step && col_vis && r_hold_valid)) begin
            r_out_pixel <= r_hold_pixel;
            r_out_last  <= i_cmd.flush;
            r_out_done  <= r_hold_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel       = r_out_pixel;
    assign o_last_of_run = r_out_last;
    assign o_image_done  = r_out_done;

`ifndef ASSERT_OFF
    a_no_step_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> !r_finished)
        else $error("run step issued after image completion");

    a_step_has_reps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> r_reps_left != '0)
        else $error("run step issued with no repetitions left");

    a_flush_has_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |-> r_hold_valid && out_free)
        else $error("flush without a held pixel or a free output");

    a_done_implies_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid && r_hold_done |-> r_finished)
        else $error("held final pixel without finished flag");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step && col_vis && r_hold_valid |-> out_free)
        else $error("output register overwritten while stalled");
`endif

endmodule

`default_nettype wire

// File: sv/pcx_rle_line_decoder.sv
// Top level of the PCX 8-bit run-length line decoder.
// Depends on prld_pkg, prld_ctrl and prld_datapath.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_data_byte) takes one encoded byte
//   per item. Output channel (o_out_valid / i_out_stall / o_pixel,
//   o_last_of_run, o_image_done) gives one visible pixel per item.
//   Configuration is written through i_cfg_wr_en / i_cfg_index / i_cfg_data
//   (0 line width, 1 bytes per line, 2 line count) while the block is idle.
// Flow:
//   A key byte is taken and starts no run; a literal is taken and decoded once; a
//   run value with count n is taken and decoded n times, one decoded byte per cycle
//   while the output is not stalled, through the column and pixel counters.
//   Each pixel waits in a hold stage until the next step or a flush so that its
//   last-of-run flag is known; the last one drains while the next item is taken.
//   After any register write the input stalls while the width-times-height
//   total is re-registered; the same applies after reset.
// Reset and stall:
//   Reset clears the run, column and pixel counters and restores the default
//   geometry (320 x 200, 320 bytes per line). A stalled output holds its item;
//   the decoder then halts and backs pressure onto the input.
//   Once the final pixel is out, later input items are taken and dropped.
`default_nettype none

module pcx_rle_line_decoder
    import prld_pkg::*;
#(
    parameter int DIM_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [7:0]           i_data_byte,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [7:0]                o_pixel,
    output logic                      o_last_of_run,
    output logic                      o_image_done
);

    t_cmd    cmd;
    t_status status;

    prld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    prld_datapath #(
        .DIM_BITS (DIM_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_data_byte   (i_data_byte),
        .i_out_stall   (i_out_stall),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .o_pixel       (o_pixel),
        .o_last_of_run (o_last_of_run),
        .o_image_done  (o_image_done)
    );

endmodule

`default_nettype wire
